@@ design/olst_pkg.sv @@
// Shared types and codes for the ordered list engine.
`timescale 1ns / 1ps

package olst_pkg;

    localparam int VAL_W       = 32;
    localparam int POS_W       = 8;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;
    localparam int CNT_OUT_W   = 5;
    localparam int MAX_RESULTS = 16;
    localparam int RUN_W       = $clog2(MAX_RESULTS);

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_READ      = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE_V  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // cell commands
    localparam logic [2:0] CC_HOLD  = 3'd0;
    localparam logic [2:0] CC_INS   = 3'd1;
    localparam logic [2:0] CC_DEL   = 3'd2;
    localparam logic [2:0] CC_MATCH = 3'd3;
    localparam logic [2:0] CC_DROP  = 3'd4;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] fill;
    } cell_ctl_t;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [VAL_W-1:0]     value;
        logic [CNT_OUT_W-1:0] count;
        logic                 last;
    } res_t;

endpackage

@@ design/olst_cell.sv @@
// One list cell: holds one entry, shifts towards either neighbour, flags a match.
`timescale 1ns / 1ps

module olst_cell #(
    parameter int IDX = 0
) (
    input  logic                     clk,
    input  olst_pkg::cell_ctl_t      ctl,
    input  logic [olst_pkg::VAL_W-1:0] left,
    input  logic [olst_pkg::VAL_W-1:0] right,
    input  logic                     seen_in,
    output logic                     seen_out,
    output logic                     first,
    output logic [olst_pkg::VAL_W-1:0] entry
);
    import olst_pkg::*;

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic             match_reg;
    logic             match_next;
    logic             valid;
    logic             hit;

    assign valid    = IDX_P < ctl.fill;
    assign hit      = match_reg & valid;
    assign first    = hit & ~seen_in;
    assign seen_out = seen_in | hit;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctl.cmd)
            CC_INS:
            begin
                if (IDX_P > ctl.pos)
                    entry_next = left;
                else if (IDX_P == ctl.pos)
                    entry_next = ctl.value;
            end
            CC_DEL:
            begin
                if (IDX_P >= ctl.pos)
                    entry_next = right;
            end
            CC_MATCH:
                match_next = (entry_reg == ctl.value);
            CC_DROP:
            begin
                if (seen_out)
                    entry_next = right;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

endmodule

@@ design/olst_outq.sv @@
// Two-deep result queue between the list and the output channel.
`timescale 1ns / 1ps

module olst_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  olst_pkg::res_t  push_data,
    output logic            space,
    output logic            out_valid,
    input  logic            out_ready,
    output olst_pkg::res_t  out_data
);
    import olst_pkg::*;

    res_t       slot_reg [2];
    logic       wr_reg;
    logic       wr_next;
    logic       rd_reg;
    logic       rd_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       pop;

    assign out_valid = (fill_reg != 2'd0);
    assign space     = (fill_reg != 2'd2);
    assign pop       = out_valid & out_ready;
    assign out_data  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? ~wr_reg : wr_reg;
        rd_next   = pop ? ~rd_reg : rd_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

endmodule

@@ design/ordered_list_engine_unit.sv @@
// Ordered list engine top level: sequencer, row of list cells, result queue.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | operation, position, item_value
//  out     | out_valid / out_ready| status, result_value, entry_count, last_of_run
//
// Append, insert, read and remove at a position finish as they are accepted:
// the cells shift in place. Remove by value goes in two steps: match flags are
// latched, then the first hit ripples down the cell chain. Clear emits one beat
// per cycle while the result queue has space. Input is held off while the two-deep
// result queue is full. Reset empties the list; cell contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [olst_pkg::OP_W-1:0]      operation,
    input  logic [olst_pkg::POS_W-1:0]     position,
    input  logic [olst_pkg::VAL_W-1:0]     item_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [olst_pkg::ST_W-1:0]      status,
    output logic [olst_pkg::VAL_W-1:0]     result_value,
    output logic [olst_pkg::CNT_OUT_W-1:0] entry_count,
    output logic                           last_of_run
);
    import olst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [RUN_W-1:0] RUN_END = RUN_W'(MAX_RESULTS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;

    cell_ctl_t        ctl;
    logic [VAL_W-1:0] entry_w [CAPACITY];
    logic             seen_w  [CAPACITY+1];
    logic             first_w [CAPACITY];
    logic [VAL_W-1:0] hit_value;
    logic [VAL_W-1:0] pos_value;
    logic             found;
    logic             space;
    logic             push;
    res_t             res;
    res_t             out_data;
    logic             accept;
    logic             last_clear;

    assign seen_w[0] = 1'b0;
    assign found     = seen_w[CAPACITY];
    assign pos_value = entry_w[position[IW-1:0]];
    assign in_ready  = (state_reg == S_IDLE) && space;
    assign accept    = in_valid && in_ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VAL_W-1:0] left_v;
            logic [VAL_W-1:0] right_v;
            if (g == 0)
            begin : g_head
                assign left_v = entry_w[g];
            end
            else
            begin : g_body
                assign left_v = entry_w[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_v = entry_w[g];
            end
            else
            begin : g_inner
                assign right_v = entry_w[g+1];
            end
            olst_cell #(
                .IDX(g)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .left     (left_v),
                .right    (right_v),
                .seen_in  (seen_w[g]),
                .seen_out (seen_w[g+1]),
                .first    (first_w[g]),
                .entry    (entry_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
            hit_value = hit_value | ({VAL_W{first_w[i]}} & entry_w[i]);
    end

    assign last_clear = (count_reg == CW'(1)) || (run_reg == RUN_END);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        run_next   = run_reg;
        ctl.cmd    = CC_HOLD;
        ctl.pos    = position;
        ctl.value  = item_value;
        ctl.fill   = POS_W'(count_reg);
        push       = 1'b0;
        res.status = ST_OK;
        res.value  = '0;
        res.count  = CNT_OUT_W'(count_reg);
        res.last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    case (operation)
                        OP_APPEND, OP_INSERT:
                        begin
                            if (count_reg >= CAP_C)
                                res.status = ST_FULL;
                            else
                            begin
                                ctl.cmd = CC_INS;
                                if (operation == OP_APPEND || position >= POS_W'(count_reg))
                                    ctl.pos = POS_W'(count_reg);
                                count_next = count_reg + CW'(1);
                                res.count  = CNT_OUT_W'(count_next);
                            end
                        end
                        OP_READ:
                        begin
                            if (position >= POS_W'(count_reg))
                                res.status = ST_MISS;
                            else
                                res.value = pos_value;
                        end
                        OP_REMOVE_AT:
                        begin
                            if (position >= POS_W'(count_reg))
                                res.status = ST_MISS;
                            else
                            begin
                                ctl.cmd    = CC_DEL;
                                res.value  = pos_value;
                                count_next = count_reg - CW'(1);
                                res.count  = CNT_OUT_W'(count_next);
                            end
                        end
                        OP_REMOVE_V:
                        begin
                            push       = 1'b0;
                            ctl.cmd    = CC_MATCH;
                            state_next = S_FIND;
                        end
                        OP_CLEAR:
                        begin
                            if (count_reg != '0)
                            begin
                                push       = 1'b0;
                                run_next   = '0;
                                state_next = S_CLEAR;
                            end
                        end
                        default:
                            res.status = ST_MISS;
                    endcase
                end
            end
            S_FIND:
            begin
                if (space)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                    if (found)
                    begin
                        ctl.cmd    = CC_DROP;
                        res.value  = hit_value;
                        count_next = count_reg - CW'(1);
                        res.count  = CNT_OUT_W'(count_next);
                    end
                    else
                        res.status = ST_MISS;
                end
            end
            S_CLEAR:
            begin
                if (space)
                begin
                    push      = 1'b1;
                    ctl.cmd   = CC_DEL;
                    ctl.pos   = '0;
                    res.value = entry_w[0];
                    run_next  = run_reg + RUN_W'(1);
                    if (last_clear)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        res.last   = 1'b0;
                    end
                    res.count = CNT_OUT_W'(count_next);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            run_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            run_reg   <= run_next;
        end
    end

    olst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign result_value = out_data.value;
    assign entry_count  = out_data.count;
    assign last_of_run  = out_data.last;

endmodule
